// ===== design/array_binary_tree_store_defines.svh =====
// assertion macros used by the checker file
`ifndef ARRAY_BINARY_TREE_STORE_DEFINES_SVH
`define ARRAY_BINARY_TREE_STORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ABTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("abts assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ABTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("abts assertion failed");

`endif

// ===== design/abts_pkg.sv =====
package abts_pkg;

	localparam int TREE_LEVELS = 7;
	localparam int VALUE_WIDTH = 32;
	localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;
	localparam int IDX_W = TREE_LEVELS;
	localparam int ADDR_W = TREE_LEVELS + 1;
	localparam int OP_W = 4;
	localparam int LEVEL_W = 3;
	localparam int ORDER_W = 7;
	localparam int STATUS_W = 2;
	localparam int OUT_W = 32;
	localparam int DEPTH_W = 3;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam addr_t NODE_CNT_A = ADDR_W'(NODE_COUNT);

	typedef enum logic [OP_W-1:0] {
		OP_READ,
		OP_WRITE,
		OP_PARENT,
		OP_LCHILD,
		OP_RCHILD,
		OP_LSIB,
		OP_RSIB,
		OP_DELETE,
		OP_CLEAR
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_EMPTY,
		ST_CHILDREN,
		ST_BAD
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_FETCH2,
		S_EXEC,
		S_DELETE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		addr_t rd_a_addr;
		addr_t rd_b_addr;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		value_t wr_data;
		logic clr_en;
		addr_t clr_addr;
		logic clr_all;
	} store_req_t;

	typedef struct packed {
		status_t status;
		logic signed [OUT_W-1:0] value_out;
		logic [DEPTH_W-1:0] tree_depth;
		logic tree_empty;
	} result_t;

	function automatic logic position_ok(logic [LEVEL_W-1:0] level, logic [ORDER_W-1:0] order);
		int first;
		if (level == '0 || int'(level) > TREE_LEVELS) begin
			return 1'b0;
		end
		first = 1 << (int'(level) - 1);
		return (order != '0) && (int'(order) <= first);
	endfunction

	function automatic addr_t position_index(logic [LEVEL_W-1:0] level,
			logic [ORDER_W-1:0] order);
		int first;
		if (level == '0) begin
			return '0;
		end
		first = 1 << (int'(level) - 1);
		return ADDR_W'(first + int'(order) - 2);
	endfunction

	function automatic logic [DEPTH_W-1:0] bit_length(addr_t n);
		int d;
		d = 0;
		for (int i = 0; i < ADDR_W; i++) begin
			if (n[i]) begin
				d = i + 1;
			end
		end
		return DEPTH_W'(d);
	endfunction

	function automatic logic signed [OUT_W-1:0] to_out(value_t v);
		logic signed [VALUE_WIDTH-1:0] s;
		s = v;
		return OUT_W'(s);
	endfunction

	function automatic addr_t child_left(addr_t i);
		return {i[ADDR_W-2:0], 1'b1};
	endfunction

	function automatic addr_t child_right(addr_t i);
		return {i[ADDR_W-2:0], 1'b0} + ADDR_W'(2);
	endfunction

	function automatic addr_t parent_of(addr_t i);
		return (i - ADDR_W'(1)) >> 1;
	endfunction

endpackage

// ===== design/abts_store.sv =====
module abts_store (
	input logic clk,
	input logic arst_n,
	input abts_pkg::store_req_t req,
	output abts_pkg::value_t rd_a_data,
	output abts_pkg::value_t rd_b_data
);

	abts_pkg::value_t mem_q [abts_pkg::NODE_COUNT];
	logic [abts_pkg::NODE_COUNT-1:0] nz_q;
	abts_pkg::value_t rd_a_raw_q;
	abts_pkg::value_t rd_b_raw_q;
	logic rd_a_hit_q;
	logic rd_b_hit_q;

	function automatic logic in_range(abts_pkg::addr_t a);
		return a < abts_pkg::NODE_CNT_A;
	endfunction

	// value array, two registered read ports
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_a_raw_q <= mem_q[req.rd_a_addr[abts_pkg::IDX_W-1:0]];
		rd_b_raw_q <= mem_q[req.rd_b_addr[abts_pkg::IDX_W-1:0]];
	end

	// per-entry nonzero flags, cleared at once on reset or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
			rd_a_hit_q <= 1'b0;
			rd_b_hit_q <= 1'b0;
		end else begin
			rd_a_hit_q <= in_range(req.rd_a_addr) && nz_q[req.rd_a_addr[abts_pkg::IDX_W-1:0]];
			rd_b_hit_q <= in_range(req.rd_b_addr) && nz_q[req.rd_b_addr[abts_pkg::IDX_W-1:0]];
			if (req.clr_all) begin
				nz_q <= '0;
			end else begin
				if (req.wr_en) begin
					nz_q[req.wr_addr] <= |req.wr_data;
				end
				if (req.clr_en && in_range(req.clr_addr)) begin
					nz_q[req.clr_addr[abts_pkg::IDX_W-1:0]] <= 1'b0;
				end
			end
		end
	end

	assign rd_a_data = rd_a_hit_q ? rd_a_raw_q : '0;
	assign rd_b_data = rd_b_hit_q ? rd_b_raw_q : '0;

endmodule

// ===== design/abts_ctrl.sv =====
module abts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [abts_pkg::OP_W-1:0] operation,
	input logic [abts_pkg::LEVEL_W-1:0] level,
	input logic [abts_pkg::ORDER_W-1:0] order,
	input logic signed [abts_pkg::OUT_W-1:0] value_in,
	input logic side,
	output logic res_valid,
	input logic res_take,
	output abts_pkg::result_t res,
	output abts_pkg::store_req_t req,
	input abts_pkg::value_t rd_a_data,
	input abts_pkg::value_t rd_b_data
);

	abts_pkg::state_t state_q, state_d;

	logic [abts_pkg::OP_W-1:0] op_q;
	logic pos_ok_q;
	abts_pkg::addr_t idx_q;
	abts_pkg::value_t val_q;
	logic side_q;
	abts_pkg::value_t pa_q;
	abts_pkg::value_t pb_q;
	abts_pkg::status_t status_q;
	logic signed [abts_pkg::OUT_W-1:0] vout_q;
	abts_pkg::addr_t scan_q;
	logic scan_vld_s1;
	abts_pkg::addr_t scan_idx_s1;
	abts_pkg::addr_t last_q;
	logic found_q;
	abts_pkg::value_t res_q;
	logic empty_q;
	abts_pkg::addr_t del_lo_q;
	abts_pkg::addr_t del_hi_q;
	abts_pkg::addr_t del_cur_q;

	abts_pkg::status_t exec_status;
	logic signed [abts_pkg::OUT_W-1:0] exec_vout;
	logic wr_go;
	logic del_go;
	logic clr_go;
	logic is_search;
	logic scan_hit;
	abts_pkg::addr_t scan_rel;
	abts_pkg::addr_t del_first;

	function automatic logic match_ok(logic [abts_pkg::OP_W-1:0] op, abts_pkg::addr_t i);
		logic ok;
		case (op) inside
			abts_pkg::OP_PARENT: ok = (i != '0);
			abts_pkg::OP_LCHILD, abts_pkg::OP_RCHILD: ok = 1'b1;
			abts_pkg::OP_LSIB: ok = (i >= abts_pkg::addr_t'(2)) && !i[0];
			abts_pkg::OP_RSIB: ok = i[0];
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	assign is_search = (op_q >= abts_pkg::OP_PARENT) && (op_q <= abts_pkg::OP_RSIB);
	assign del_first = abts_pkg::child_left(idx_q) + abts_pkg::addr_t'(side_q);

	// related entry read on the second port during the scan
	always_comb begin
		case (op_q) inside
			abts_pkg::OP_PARENT: scan_rel = abts_pkg::parent_of(scan_q);
			abts_pkg::OP_LCHILD: scan_rel = abts_pkg::child_left(scan_q);
			abts_pkg::OP_RCHILD: scan_rel = abts_pkg::child_right(scan_q);
			abts_pkg::OP_LSIB: scan_rel = scan_q - abts_pkg::addr_t'(1);
			abts_pkg::OP_RSIB: scan_rel = scan_q + abts_pkg::addr_t'(1);
			default: scan_rel = scan_q;
		endcase
	end

	assign scan_hit = (val_q != '0) && (rd_a_data == val_q) && match_ok(op_q, scan_idx_s1);

	// decision once the addressed node (its parent for a write) and its children are fetched
	always_comb begin
		exec_status = abts_pkg::ST_OK;
		exec_vout = '0;
		wr_go = 1'b0;
		del_go = 1'b0;
		clr_go = 1'b0;
		case (op_q) inside
			abts_pkg::OP_READ: begin
				if (!pos_ok_q) begin
					exec_status = abts_pkg::ST_BAD;
				end else begin
					exec_vout = abts_pkg::to_out(pa_q);
				end
			end
			abts_pkg::OP_WRITE: begin
				if (!pos_ok_q) begin
					exec_status = abts_pkg::ST_BAD;
				end else if (val_q != '0 && idx_q != '0 && pa_q == '0) begin
					exec_status = abts_pkg::ST_EMPTY;
				end else if (val_q == '0 && (pb_q != '0 || rd_a_data != '0)) begin
					exec_status = abts_pkg::ST_CHILDREN;
				end else begin
					wr_go = 1'b1;
				end
			end
			abts_pkg::OP_PARENT, abts_pkg::OP_LCHILD, abts_pkg::OP_RCHILD,
			abts_pkg::OP_LSIB, abts_pkg::OP_RSIB: begin
				exec_status = abts_pkg::ST_OK;
			end
			abts_pkg::OP_DELETE: begin
				if (!pos_ok_q) begin
					exec_status = abts_pkg::ST_BAD;
				end else if (pa_q == '0) begin
					exec_status = abts_pkg::ST_EMPTY;
				end else begin
					del_go = 1'b1;
				end
			end
			abts_pkg::OP_CLEAR: begin
				clr_go = 1'b1;
			end
			default: begin
				exec_status = abts_pkg::ST_BAD;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			abts_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = abts_pkg::S_FETCH;
				end
			end
			abts_pkg::S_FETCH: state_d = abts_pkg::S_FETCH2;
			abts_pkg::S_FETCH2: state_d = abts_pkg::S_EXEC;
			abts_pkg::S_EXEC: begin
				state_d = del_go ? abts_pkg::S_DELETE : abts_pkg::S_SCAN;
			end
			abts_pkg::S_DELETE: begin
				if (del_cur_q >= abts_pkg::NODE_CNT_A) begin
					state_d = abts_pkg::S_SCAN;
				end
			end
			abts_pkg::S_SCAN: begin
				if (scan_q == abts_pkg::NODE_CNT_A && scan_vld_s1) begin
					state_d = abts_pkg::S_DONE;
				end
			end
			abts_pkg::S_DONE: begin
				if (res_take) begin
					state_d = abts_pkg::S_IDLE;
				end
			end
			default: state_d = abts_pkg::S_IDLE;
		endcase
	end

	// outputs and store requests
	always_comb begin
		in_stall = 1'b1;
		res_valid = 1'b0;
		req = '0;
		unique case (state_q)
			abts_pkg::S_IDLE: in_stall = 1'b0;
			abts_pkg::S_FETCH: begin
				req.rd_a_addr = (op_q == abts_pkg::OP_WRITE) ? abts_pkg::parent_of(idx_q) : idx_q;
				req.rd_b_addr = abts_pkg::child_left(idx_q);
			end
			abts_pkg::S_FETCH2: req.rd_a_addr = abts_pkg::child_right(idx_q);
			abts_pkg::S_EXEC: begin
				req.wr_en = wr_go;
				req.wr_addr = idx_q[abts_pkg::IDX_W-1:0];
				req.wr_data = val_q;
				req.clr_all = clr_go;
			end
			abts_pkg::S_DELETE: begin
				req.clr_en = del_cur_q < abts_pkg::NODE_CNT_A;
				req.clr_addr = del_cur_q;
			end
			abts_pkg::S_SCAN: begin
				req.rd_a_addr = scan_q;
				req.rd_b_addr = scan_rel;
			end
			abts_pkg::S_DONE: res_valid = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	always_comb begin
		res.tree_depth = abts_pkg::bit_length(last_q);
		res.tree_empty = empty_q;
		if (is_search) begin
			res.status = (found_q && !empty_q) ? abts_pkg::ST_OK : abts_pkg::ST_EMPTY;
			res.value_out = (found_q && !empty_q) ? abts_pkg::to_out(res_q) : '0;
		end else begin
			res.status = status_q;
			res.value_out = vout_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abts_pkg::S_IDLE;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_vld_s1 <= (state_q == abts_pkg::S_SCAN) && (scan_q < abts_pkg::NODE_CNT_A);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			abts_pkg::S_IDLE: begin
				if (in_valid) begin
					op_q <= operation;
					pos_ok_q <= abts_pkg::position_ok(level, order);
					idx_q <= abts_pkg::position_ok(level, order) ?
						abts_pkg::position_index(level, order) : '0;
					val_q <= abts_pkg::VALUE_WIDTH'(value_in);
					side_q <= side;
					scan_q <= '0;
					last_q <= '0;
					found_q <= 1'b0;
					empty_q <= 1'b1;
				end
			end
			abts_pkg::S_FETCH2: begin
				pa_q <= rd_a_data;
				pb_q <= rd_b_data;
			end
			abts_pkg::S_EXEC: begin
				status_q <= exec_status;
				vout_q <= exec_vout;
				del_lo_q <= del_first;
				del_hi_q <= del_first;
				del_cur_q <= del_first;
			end
			abts_pkg::S_DELETE: begin
				// walk the subtree one level range at a time
				if (del_cur_q == del_hi_q) begin
					del_lo_q <= abts_pkg::child_left(del_lo_q);
					del_hi_q <= abts_pkg::child_right(del_hi_q);
					del_cur_q <= abts_pkg::child_left(del_lo_q);
				end else begin
					del_cur_q <= del_cur_q + abts_pkg::addr_t'(1);
				end
			end
			abts_pkg::S_SCAN: begin
				if (scan_q < abts_pkg::NODE_CNT_A) begin
					scan_q <= scan_q + abts_pkg::addr_t'(1);
				end
				scan_idx_s1 <= scan_q;
				if (scan_vld_s1) begin
					if (rd_a_data != '0) begin
						last_q <= scan_idx_s1 + abts_pkg::addr_t'(1);
					end
					if (scan_idx_s1 == '0) begin
						empty_q <= (rd_a_data == '0);
					end
					// later matches overwrite earlier ones
					if (scan_hit) begin
						found_q <= 1'b1;
						res_q <= rd_b_data;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/array_binary_tree_store.sv =====
// Binary tree store in heap order: node (level, order) lives at entry
// 2^(level-1)+order-2 of a 127-entry value memory, zero meaning empty, with
// the children of entry i at 2i+1 and 2i+2. One operation per input beat:
// read or write by position, search by value (parent, child or sibling of
// the highest-index match), delete the left or right subtree of a node, or
// clear. Each beat yields exactly one result beat with a status, a value,
// the tree depth and an empty flag. The block works on one beat at a time:
// in_stall stays high from acceptance until the result has been loaded
// into the output register, so a new beat can be taken while the previous
// result still waits on out_stall. Every operation ends with a summary
// scan that reads every memory entry once through the store's first read
// port; delete subtree first walks and clears every entry of the removed
// subtree that lies inside the store.
// Reset and clear empty the store at once through per-entry flags, so
// there is no clearing pass.
module array_binary_tree_store (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [abts_pkg::OP_W-1:0] operation,
	input logic [abts_pkg::LEVEL_W-1:0] level,
	input logic [abts_pkg::ORDER_W-1:0] order,
	input logic signed [abts_pkg::OUT_W-1:0] value_in,
	input logic side,
	output logic out_valid,
	input logic out_stall,
	output logic [abts_pkg::STATUS_W-1:0] status,
	output logic signed [abts_pkg::OUT_W-1:0] value_out,
	output logic [abts_pkg::DEPTH_W-1:0] tree_depth,
	output logic tree_empty
);

	// sequencer to store requests and read data
	abts_pkg::store_req_t req;
	abts_pkg::value_t rd_a_data;
	abts_pkg::value_t rd_b_data;

	// finished result from the sequencer
	abts_pkg::result_t res;
	logic res_valid;
	logic res_take;

	// output register
	logic out_valid_q;
	abts_pkg::result_t out_res_q;

	abts_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation (operation),
		.level (level),
		.order (order),
		.value_in (value_in),
		.side (side),
		.res_valid (res_valid),
		.res_take (res_take),
		.res (res),
		.req (req),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	abts_store u_store (
		.clk (clk),
		.arst_n (arst_n),
		.req (req),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	// the register can take a new result when empty or being drained
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_res_q.status;
	assign value_out = out_res_q.value_out;
	assign tree_depth = out_res_q.tree_depth;
	assign tree_empty = out_res_q.tree_empty;

endmodule

// ===== design/abts_checker.sv =====
`include "array_binary_tree_store_defines.svh"

module abts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [abts_pkg::STATUS_W-1:0] status,
	input logic signed [abts_pkg::OUT_W-1:0] value_out,
	input logic [abts_pkg::DEPTH_W-1:0] tree_depth,
	input logic tree_empty
);

	// a held result keeps its value
	`ABTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(value_out))

	// one beat at a time: busy right after an accept
	`ABTS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// no node without a parent, so an empty root means no nodes at all
	`ABTS_ASSERT_IMPL(a_empty_depth, clk, arst_n, out_valid, tree_empty == (tree_depth == '0))

	// a rejected position never returns data
	`ABTS_ASSERT_IMPL(a_bad_zero, clk, arst_n, out_valid && status == abts_pkg::ST_BAD, value_out == '0)

endmodule

bind array_binary_tree_store abts_checker u_abts_checker (
	.clk (clk),
	.arst_n (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status (status),
	.value_out (value_out),
	.tree_depth (tree_depth),
	.tree_empty (tree_empty)
);
